[rtl/clock_countdown_digit_display_defines.svh]
// assertion macros used by the rtl file clock_countdown_digit_display.sv
// the checks expect a clock named clk and an active-low reset named rst_n in scope
`ifndef CLOCK_COUNTDOWN_DIGIT_DISPLAY_DEFINES_SVH
`define CLOCK_COUNTDOWN_DIGIT_DISPLAY_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define CCDD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ccdd assertion failed");

// checked during reset as well
`define CCDD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ccdd reset assertion failed");

`else

`define CCDD_ASSERT(label, prop)
`define CCDD_ASSERT_RST(label, prop)

`endif

`endif

[rtl/ccdd_pkg.sv]
`default_nettype none

package ccdd_pkg;

  // input mode codes
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_SET_TIME = 2'd1;
  localparam logic [1:0] MODE_START_CD = 2'd2;

  // display mode codes
  localparam logic [2:0] DISP_OFF     = 3'd0;
  localparam logic [2:0] DISP_TIME    = 3'd1;
  localparam logic [2:0] DISP_CD      = 3'd2;
  localparam logic [2:0] DISP_USER    = 3'd3;
  localparam logic [2:0] DISP_PATTERN = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_DIGITS  = 2'd1;

  localparam logic [3:0] TENTHS_MAX  = 4'd9;
  localparam logic [5:0] SEC_MAX     = 6'd59;
  localparam logic [5:0] MIN_MAX     = 6'd59;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [6:0] CD_HOUR_MAX = 7'd99;
  localparam logic [3:0] DIGIT_BLANK = 4'd10;
  localparam logic [3:0] AUX_ON      = 4'd8;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;

  // reset time of day
  localparam logic [5:0] TOD_SEC_RST  = 6'd56;
  localparam logic [5:0] TOD_MIN_RST  = 6'd34;
  localparam logic [4:0] TOD_HOUR_RST = 5'd12;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] set_hours;
    logic [5:0] set_minutes;
  } in_t;

  typedef struct packed {
    logic [3:0] aux_digit;
    logic [3:0] digit_tenths;
    logic [3:0] digit_sec_ones;
    logic [3:0] digit_sec_tens;
    logic [3:0] digit_min_ones;
    logic [3:0] digit_min_tens;
    logic [3:0] digit_hour_ones;
    logic [3:0] digit_hour_tens;
    logic       countdown_running;
  } out_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd_t;

  // two decimal digits of a 7-bit value, tens digit taken modulo ten
  function automatic bcd_t to_bcd(input logic [6:0] v);
    bcd_t       r;
    logic [3:0] t;
    logic [6:0] base;
    t = '0;
    for (int i = 1; i < 13; i++) begin
      if (v >= 7'(10 * i)) t = 4'(i);
    end
    base = 7'(t * 10);
    r.ones = 4'(v - base);
    r.tens = (t > DIGIT_MAX) ? 4'(t - 4'd10) : t;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/clock_countdown_digit_display.sv]
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------
// in       | in_valid / in_stall  | in_data (mode, set_hours, set_minutes)
// out      | out_valid / out_stall| out_data (eight digits, countdown_running)
// cfg      | cfg_we               | cfg_index, cfg_wdata
//
// one item is accepted per clock while in_stall is low; its state update is a single registered pass
// a tick result shows up in the output register the cycle after acceptance
// set items, countdown starts, unused-mode items and non-emitting ticks leave no result
// in_stall rises only while a result is held in the output register and out_stall is high
// rst_n is synchronous: time of day returns to 12:34:56.0, countdown and registers clear
`default_nettype none
`include "clock_countdown_digit_display_defines.svh"

module clock_countdown_digit_display
  import ccdd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [2:0]  display_mode_r;
  logic [27:0] user_digits_r;

  logic [3:0] tod_tenths_r, tod_tenths_nxt;
  logic [5:0] tod_seconds_r, tod_seconds_nxt;
  logic [5:0] tod_minutes_r, tod_minutes_nxt;
  logic [4:0] tod_hours_r, tod_hours_nxt;
  logic [3:0] cd_tenths_r, cd_tenths_nxt;
  logic [5:0] cd_seconds_r, cd_seconds_nxt;
  logic [5:0] cd_minutes_r, cd_minutes_nxt;
  logic [6:0] cd_hours_r, cd_hours_nxt;
  logic       cd_enabled_r, cd_enabled_nxt;
  logic [3:0] pattern_value_r, pattern_value_nxt;

  logic out_valid_r, emit_nxt;
  out_t out_data_r, out_data_nxt;

  // tick path values
  logic [3:0] tk_tod_tenths, tk_cd_tenths;
  logic [5:0] tk_tod_seconds, tk_tod_minutes, tk_cd_seconds, tk_cd_minutes;
  logic [4:0] tk_tod_hours;
  logic [6:0] tk_cd_hours;
  logic       tk_cd_enabled;
  logic [3:0] pv;
  bcd_t       b_sec, b_min, b_hour, b_cds, b_cdm, b_cdh;
  logic       in_fire;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  function automatic logic [3:0] user_digit(input logic [3:0] nib);
    return (nib > DIGIT_MAX) ? DIGIT_BLANK : nib;
  endfunction

  // countdown with borrow, stops at zero
  always_comb begin
    tk_cd_tenths  = cd_tenths_r;
    tk_cd_seconds = cd_seconds_r;
    tk_cd_minutes = cd_minutes_r;
    tk_cd_hours   = cd_hours_r;
    tk_cd_enabled = cd_enabled_r;
    if (cd_enabled_r) begin
      if (cd_tenths_r != '0) begin
        tk_cd_tenths = cd_tenths_r - 4'd1;
      end else begin
        tk_cd_tenths = TENTHS_MAX;
        if (cd_seconds_r != '0) begin
          tk_cd_seconds = cd_seconds_r - 6'd1;
        end else begin
          tk_cd_seconds = SEC_MAX;
          if (cd_minutes_r != '0) begin
            tk_cd_minutes = cd_minutes_r - 6'd1;
          end else begin
            tk_cd_minutes = MIN_MAX;
            if (cd_hours_r != '0) begin
              tk_cd_hours = cd_hours_r - 7'd1;
            end else begin
              tk_cd_enabled = 1'b0;
              tk_cd_hours   = '0;
              tk_cd_minutes = '0;
              tk_cd_seconds = '0;
              tk_cd_tenths  = '0;
            end
          end
        end
      end
    end
    if (tk_cd_hours == '0 && tk_cd_minutes == '0 && tk_cd_seconds == '0 &&
        tk_cd_tenths == '0) begin
      tk_cd_enabled = 1'b0;
    end
  end

  // time of day advance with 24-hour wrap
  always_comb begin
    tk_tod_tenths  = tod_tenths_r + 4'd1;
    tk_tod_seconds = tod_seconds_r;
    tk_tod_minutes = tod_minutes_r;
    tk_tod_hours   = tod_hours_r;
    if (tk_tod_tenths > TENTHS_MAX) begin
      tk_tod_tenths  = '0;
      tk_tod_seconds = tod_seconds_r + 6'd1;
      if (tk_tod_seconds > SEC_MAX) begin
        tk_tod_seconds = '0;
        tk_tod_minutes = tod_minutes_r + 6'd1;
        if (tk_tod_minutes > MIN_MAX) begin
          tk_tod_minutes = '0;
          tk_tod_hours   = tod_hours_r + 5'd1;
          if (tk_tod_hours > HOUR_MAX) tk_tod_hours = '0;
        end
      end
    end
  end

  assign b_sec  = to_bcd({1'b0, tk_tod_seconds});
  assign b_min  = to_bcd({1'b0, tk_tod_minutes});
  assign b_hour = to_bcd({2'b0, tk_tod_hours});
  assign b_cds  = to_bcd({1'b0, tk_cd_seconds});
  assign b_cdm  = to_bcd({1'b0, tk_cd_minutes});
  assign b_cdh  = to_bcd(tk_cd_hours);
  assign pv     = (pattern_value_r > DIGIT_MAX) ? 4'd0 : pattern_value_r;

  always_comb begin
    tod_tenths_nxt    = tod_tenths_r;
    tod_seconds_nxt   = tod_seconds_r;
    tod_minutes_nxt   = tod_minutes_r;
    tod_hours_nxt     = tod_hours_r;
    cd_tenths_nxt     = cd_tenths_r;
    cd_seconds_nxt    = cd_seconds_r;
    cd_minutes_nxt    = cd_minutes_r;
    cd_hours_nxt      = cd_hours_r;
    cd_enabled_nxt    = cd_enabled_r;
    pattern_value_nxt = pattern_value_r;
    emit_nxt          = 1'b0;
    out_data_nxt      = '0;
    case (in_data.mode)
      MODE_SET_TIME: begin
        tod_hours_nxt   = (in_data.set_hours > {2'b0, HOUR_MAX}) ? HOUR_MAX :
                          in_data.set_hours[4:0];
        tod_minutes_nxt = (in_data.set_minutes > MIN_MAX) ? MIN_MAX : in_data.set_minutes;
        tod_seconds_nxt = '0;
        tod_tenths_nxt  = '0;
      end
      MODE_START_CD: begin
        cd_hours_nxt   = (in_data.set_hours > CD_HOUR_MAX) ? CD_HOUR_MAX : in_data.set_hours;
        cd_minutes_nxt = (in_data.set_minutes > MIN_MAX) ? MIN_MAX : in_data.set_minutes;
        cd_seconds_nxt = '0;
        cd_tenths_nxt  = '0;
        cd_enabled_nxt = 1'b1;
      end
      MODE_TICK: begin
        tod_tenths_nxt  = tk_tod_tenths;
        tod_seconds_nxt = tk_tod_seconds;
        tod_minutes_nxt = tk_tod_minutes;
        tod_hours_nxt   = tk_tod_hours;
        cd_tenths_nxt   = tk_cd_tenths;
        cd_seconds_nxt  = tk_cd_seconds;
        cd_minutes_nxt  = tk_cd_minutes;
        cd_hours_nxt    = tk_cd_hours;
        cd_enabled_nxt  = tk_cd_enabled;
        out_data_nxt.countdown_running = tk_cd_enabled;
        case (display_mode_r)
          DISP_OFF: begin
            emit_nxt = 1'b1;
            out_data_nxt.aux_digit       = DIGIT_BLANK;
            out_data_nxt.digit_tenths    = DIGIT_BLANK;
            out_data_nxt.digit_sec_ones  = DIGIT_BLANK;
            out_data_nxt.digit_sec_tens  = DIGIT_BLANK;
            out_data_nxt.digit_min_ones  = DIGIT_BLANK;
            out_data_nxt.digit_min_tens  = DIGIT_BLANK;
            out_data_nxt.digit_hour_ones = DIGIT_BLANK;
            out_data_nxt.digit_hour_tens = DIGIT_BLANK;
          end
          DISP_TIME: begin
            emit_nxt = 1'b1;
            out_data_nxt.aux_digit       = AUX_ON;
            out_data_nxt.digit_tenths    = tk_tod_tenths;
            out_data_nxt.digit_sec_ones  = b_sec.ones;
            out_data_nxt.digit_sec_tens  = b_sec.tens;
            out_data_nxt.digit_min_ones  = b_min.ones;
            out_data_nxt.digit_min_tens  = b_min.tens;
            out_data_nxt.digit_hour_ones = b_hour.ones;
            out_data_nxt.digit_hour_tens = b_hour.tens;
          end
          DISP_CD: begin
            emit_nxt = 1'b1;
            out_data_nxt.aux_digit       = AUX_ON;
            out_data_nxt.digit_tenths    = tk_cd_tenths;
            out_data_nxt.digit_sec_ones  = b_cds.ones;
            out_data_nxt.digit_sec_tens  = b_cds.tens;
            out_data_nxt.digit_min_ones  = b_cdm.ones;
            out_data_nxt.digit_min_tens  = b_cdm.tens;
            out_data_nxt.digit_hour_ones = b_cdh.ones;
            out_data_nxt.digit_hour_tens = b_cdh.tens;
          end
          DISP_USER: begin
            emit_nxt = 1'b1;
            out_data_nxt.aux_digit       = DIGIT_BLANK;
            out_data_nxt.digit_tenths    = user_digit(user_digits_r[3:0]);
            out_data_nxt.digit_sec_ones  = user_digit(user_digits_r[7:4]);
            out_data_nxt.digit_sec_tens  = user_digit(user_digits_r[11:8]);
            out_data_nxt.digit_min_ones  = user_digit(user_digits_r[15:12]);
            out_data_nxt.digit_min_tens  = user_digit(user_digits_r[19:16]);
            out_data_nxt.digit_hour_ones = user_digit(user_digits_r[23:20]);
            out_data_nxt.digit_hour_tens = user_digit(user_digits_r[27:24]);
          end
          DISP_PATTERN: begin
            // steps only on whole seconds
            if (tk_tod_tenths == '0) begin
              emit_nxt = 1'b1;
              pattern_value_nxt = pv + 4'd1;
              out_data_nxt.aux_digit       = AUX_ON;
              out_data_nxt.digit_tenths    = pv;
              out_data_nxt.digit_sec_ones  = pv;
              out_data_nxt.digit_sec_tens  = pv;
              out_data_nxt.digit_min_ones  = pv;
              out_data_nxt.digit_min_tens  = pv;
              out_data_nxt.digit_hour_ones = pv;
              out_data_nxt.digit_hour_tens = pv;
            end
          end
          default: begin
            emit_nxt = 1'b0;
          end
        endcase
      end
      default: begin
        emit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r  <= DISP_OFF;
      user_digits_r   <= '0;
      tod_tenths_r    <= '0;
      tod_seconds_r   <= TOD_SEC_RST;
      tod_minutes_r   <= TOD_MIN_RST;
      tod_hours_r     <= TOD_HOUR_RST;
      cd_tenths_r     <= '0;
      cd_seconds_r    <= '0;
      cd_minutes_r    <= '0;
      cd_hours_r      <= '0;
      cd_enabled_r    <= 1'b0;
      pattern_value_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DISPLAY_MODE: display_mode_r <= cfg_wdata[2:0];
          REG_USER_DIGITS:  user_digits_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        tod_tenths_r    <= tod_tenths_nxt;
        tod_seconds_r   <= tod_seconds_nxt;
        tod_minutes_r   <= tod_minutes_nxt;
        tod_hours_r     <= tod_hours_nxt;
        cd_tenths_r     <= cd_tenths_nxt;
        cd_seconds_r    <= cd_seconds_nxt;
        cd_minutes_r    <= cd_minutes_nxt;
        cd_hours_r      <= cd_hours_nxt;
        cd_enabled_r    <= cd_enabled_nxt;
        pattern_value_r <= pattern_value_nxt;
        out_valid_r     <= emit_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, loaded only when a new result is produced
  always_ff @(posedge clk) begin
    if (in_fire && emit_nxt) out_data_r <= out_data_nxt;
  end

  `CCDD_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_valid_r)
  `CCDD_ASSERT(a_set_no_result, (in_fire && in_data.mode != MODE_TICK) |=> !out_valid_r)
  `CCDD_ASSERT(a_tod_range, tod_tenths_r <= TENTHS_MAX && tod_seconds_r <= SEC_MAX &&
                            tod_minutes_r <= MIN_MAX && tod_hours_r <= HOUR_MAX)
  `CCDD_ASSERT(a_cd_range, cd_tenths_r <= TENTHS_MAX && cd_seconds_r <= SEC_MAX &&
                           cd_minutes_r <= MIN_MAX && cd_hours_r <= CD_HOUR_MAX)
  `CCDD_ASSERT(a_pattern_range, pattern_value_r <= DIGIT_BLANK)

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ccdd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] DISP_UNUSED_MAX = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int ITEM_TARGET = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  clock_countdown_digit_display i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow of the block's registers and counters
  logic [2:0] disp_mode = DISP_OFF;
  logic [27:0] user_digits = '0;
  logic [3:0] tod_tenths = '0;
  logic [5:0] tod_seconds = TOD_SEC_RST;
  logic [5:0] tod_minutes = TOD_MIN_RST;
  logic [4:0] tod_hours = TOD_HOUR_RST;
  logic [3:0] cd_tenths = '0;
  logic [5:0] cd_seconds = '0;
  logic [5:0] cd_minutes = '0;
  logic [6:0] cd_hours = '0;
  logic cd_on = 1'b0;
  logic [3:0] pattern_value = '0;

  in_t items_to_send [$];
  out_t digits_due [$];
  int queued_total = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  // driver state
  int burst_left = 1;
  int idle_left = 0;
  out_t shown_next;
  bit emits;

  // receiver state
  int hold_left = 0;
  int stall_style = 0;
  int stall_seg_left = 0;
  int stall_period = 2;
  int stall_tick = 0;
  out_t oldest_digits;
  logic [32:0] got_bits;
  logic [32:0] want_bits;
  string digit_names [0:7] = '{"aux_digit", "digit_tenths", "digit_sec_ones",
                               "digit_sec_tens", "digit_min_ones", "digit_min_tens",
                               "digit_hour_ones", "digit_hour_tens"};

  function automatic logic [31:0] counter_digits(input int t, input int s, input int m,
                                                 input int h);
    return {AUX_ON, 4'(t % 10), 4'(s % 10), 4'((s / 10) % 10), 4'(m % 10),
            4'((m / 10) % 10), 4'(h % 10), 4'((h / 10) % 10)};
  endfunction

  // applies one transaction to the shadow state, returns 1 when digits are latched
  function automatic bit display_after_item(input in_t item, output out_t shown);
    logic [31:0] digs;
    logic [3:0] nib;
    shown = '0;
    digs = '0;
    case (item.mode)
      MODE_SET_TIME: begin
        tod_hours = (item.set_hours > 7'(HOUR_MAX)) ? HOUR_MAX : item.set_hours[4:0];
        tod_minutes = (item.set_minutes > MIN_MAX) ? MIN_MAX : item.set_minutes;
        tod_seconds = '0;
        tod_tenths = '0;
        return 1'b0;
      end
      MODE_START_CD: begin
        cd_hours = (item.set_hours > CD_HOUR_MAX) ? CD_HOUR_MAX : item.set_hours;
        cd_minutes = (item.set_minutes > MIN_MAX) ? MIN_MAX : item.set_minutes;
        cd_seconds = '0;
        cd_tenths = '0;
        cd_on = 1'b1;
        return 1'b0;
      end
      MODE_TICK: ;
      default: return 1'b0;
    endcase

    // countdown with borrow, stops at zero
    if (cd_on) begin
      if (cd_tenths != 0) begin
        cd_tenths = cd_tenths - 1'b1;
      end else begin
        cd_tenths = TENTHS_MAX;
        if (cd_seconds != 0) begin
          cd_seconds = cd_seconds - 1'b1;
        end else begin
          cd_seconds = SEC_MAX;
          if (cd_minutes != 0) begin
            cd_minutes = cd_minutes - 1'b1;
          end else begin
            cd_minutes = MIN_MAX;
            if (cd_hours != 0) begin
              cd_hours = cd_hours - 1'b1;
            end else begin
              cd_on = 1'b0;
              cd_hours = '0;
              cd_minutes = '0;
              cd_seconds = '0;
              cd_tenths = '0;
            end
          end
        end
      end
    end
    if (cd_hours == 0 && cd_minutes == 0 && cd_seconds == 0 && cd_tenths == 0) cd_on = 1'b0;

    tod_tenths = tod_tenths + 1'b1;
    if (tod_tenths > TENTHS_MAX) begin
      tod_tenths = '0;
      tod_seconds = tod_seconds + 1'b1;
      if (tod_seconds > SEC_MAX) begin
        tod_seconds = '0;
        tod_minutes = tod_minutes + 1'b1;
        if (tod_minutes > MIN_MAX) begin
          tod_minutes = '0;
          tod_hours = tod_hours + 1'b1;
          if (tod_hours > HOUR_MAX) tod_hours = '0;
        end
      end
    end

    case (disp_mode)
      DISP_OFF: digs = {8{DIGIT_BLANK}};
      DISP_TIME: digs = counter_digits(int'(tod_tenths), int'(tod_seconds),
                                       int'(tod_minutes), int'(tod_hours));
      DISP_CD: digs = counter_digits(int'(cd_tenths), int'(cd_seconds),
                                     int'(cd_minutes), int'(cd_hours));
      DISP_USER: begin
        digs[31:28] = DIGIT_BLANK;
        for (int i = 1; i < 8; i++) begin
          nib = user_digits[4*(i-1) +: 4];
          digs[31-4*i -: 4] = (nib > DIGIT_MAX) ? DIGIT_BLANK : nib;
        end
      end
      DISP_PATTERN: begin
        // pattern only steps on whole seconds
        if (tod_tenths != 0) return 1'b0;
        if (pattern_value > DIGIT_MAX) pattern_value = '0;
        digs = {AUX_ON, {7{pattern_value}}};
        pattern_value = pattern_value + 1'b1;
      end
      default: return 1'b0;
    endcase
    shown = out_t'({digs, cd_on});
    return 1'b1;
  endfunction

  task automatic queue_item(input logic [1:0] mode, input int hrs, input int mins);
    in_t item;
    item.mode = mode;
    item.set_hours = 7'(hrs);
    item.set_minutes = 6'(mins);
    items_to_send.push_back(item);
    if (mode != MODE_UNUSED) queued_total++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_item(MODE_TICK, $urandom_range(0, 127), $urandom_range(0, 63));
  endtask

  // waits until every queued transaction is sent and every result has come back
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid || digits_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DISPLAY_MODE: disp_mode = val[2:0];
      REG_USER_DIGITS: user_digits = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        emits = display_after_item(in_data, shown_next);
        if (emits) digits_due.push_back(shown_next);
      end
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          in_data <= items_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and stalls on its own pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (digits_due.size() == 0) begin
          $error("result with no expected digits pending");
          mismatch_count++;
        end else begin
          oldest_digits = digits_due.pop_front();
          got_bits = out_data;
          want_bits = oldest_digits;
          for (int k = 0; k < 8; k++) begin
            if (got_bits[32-4*k -: 4] !== want_bits[32-4*k -: 4]) begin
              $error("%s expected %0d actual %0d", digit_names[k],
                     want_bits[32-4*k -: 4], got_bits[32-4*k -: 4]);
              mismatch_count++;
            end
          end
          if (out_data.countdown_running !== oldest_digits.countdown_running) begin
            $error("countdown_running expected %0d actual %0d",
                   oldest_digits.countdown_running, out_data.countdown_running);
            mismatch_count++;
          end
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 150 || results_seen == 1000) hold_left = HOLD_CYCLES;
      end
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_seg_left == 0) begin
          stall_style = $urandom_range(0, 3);
          stall_seg_left = $urandom_range(20, 200);
          stall_period = $urandom_range(2, 6);
        end else begin
          stall_seg_left--;
        end
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ((stall_tick % stall_period) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase_no;
    int phase_end;
    logic [2:0] next_disp;
    logic [27:0] next_user;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: display off after reset
    queue_ticks(1);
    wait_idle();

    // time of day, saturating loads, ignored mode
    write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(DISP_TIME));
    queue_ticks(1);
    queue_item(MODE_SET_TIME, 127, 63);
    queue_ticks(1);
    queue_item(MODE_SET_TIME, 0, 0);
    queue_item(MODE_UNUSED, 127, 63);
    queue_ticks(1);
    wait_idle();

    // countdown: start from zero, borrow through hours, saturation
    write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(DISP_CD));
    queue_item(MODE_START_CD, 0, 0);
    queue_ticks(1);
    queue_item(MODE_START_CD, 1, 0);
    queue_ticks(1);
    queue_item(MODE_START_CD, 127, 63);
    queue_ticks(2);
    queue_item(MODE_START_CD, 0, 1);
    queue_ticks(1);
    wait_idle();

    // user digits with nibbles above nine
    write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(DISP_USER));
    write_reg(REG_USER_DIGITS, 28'hFEDCBA9);
    queue_ticks(1);
    wait_idle();
    write_reg(REG_USER_DIGITS, 28'hFFFFFFF);
    queue_ticks(1);
    wait_idle();
    write_reg(REG_USER_DIGITS, 28'h0);
    queue_ticks(1);
    wait_idle();

    // unused display mode, then pattern around a whole second
    write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(DISP_UNUSED_MAX));
    queue_ticks(1);
    wait_idle();
    write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(DISP_PATTERN));
    queue_ticks(6);
    wait_idle();

    phase_no = 0;
    while (queued_total < ITEM_TARGET) begin
      case (phase_no)
        0: next_disp = DISP_TIME;
        1: next_disp = DISP_PATTERN;
        2: next_disp = DISP_UNUSED_MAX;
        default: next_disp = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                        : 3'($urandom_range(5, 7));
      endcase
      case ($urandom_range(0, 3))
        0: next_user = '0;
        1: next_user = 28'hFFFFFFF;
        default: next_user = 28'($urandom);
      endcase
      write_reg(REG_DISPLAY_MODE, CFG_DATA_W'(next_disp));
      write_reg(REG_USER_DIGITS, next_user);
      if (phase_no == 0) begin
        // midnight wrap and a countdown running out
        queue_item(MODE_SET_TIME, 23, 59);
        queue_item(MODE_START_CD, 0, 1);
        queue_ticks(610);
      end else if (phase_no == 1) begin
        queue_ticks(120);
      end else begin
        phase_end = queued_total + 120;
        while (queued_total < phase_end) begin
          case ($urandom_range(0, 9))
            0, 1: begin
              if ($urandom_range(0, 1) == 1)
                queue_item(MODE_SET_TIME, $urandom_range(20, 23), $urandom_range(55, 59));
              else
                queue_item(MODE_SET_TIME, $urandom_range(0, 127), $urandom_range(0, 63));
              queue_ticks($urandom_range(1, 60));
            end
            2, 3: begin
              if ($urandom_range(0, 1) == 1)
                queue_item(MODE_START_CD, $urandom_range(0, 1), $urandom_range(0, 2));
              else
                queue_item(MODE_START_CD, $urandom_range(0, 127), $urandom_range(0, 63));
              queue_ticks($urandom_range(1, 60));
            end
            4: begin
              repeat ($urandom_range(1, 3))
                queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 127),
                           $urandom_range(0, 63));
            end
            default: queue_ticks($urandom_range(1, 30));
          endcase
        end
      end
      wait_idle();
      phase_no++;
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && digits_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[clock_countdown_digit_display.f]
+incdir+rtl
rtl/ccdd_pkg.sv
rtl/clock_countdown_digit_display.sv
tb/testbench.sv
